/* hdl/seg_pkg.sv */
// Shared types, constants and the SipHash round function for the edge seed generator.
// Used by every module in hdl/ except seg_checker; depends on nothing else.
`timescale 1ns / 1ps
package seg_pkg;

  localparam int MAX_EDGE_WIDTH   = 32;
  localparam int MIN_EDGE_WIDTH   = 12;
  localparam int ELEMENT_BYTES    = 5;
  localparam int MAX_BUCKET_WIDTH = 8;
  localparam int SIP_ROUNDS       = 6;
  // The finalization xor goes in ahead of this round (after the two compression rounds).
  localparam int FINAL_ROUND      = 2;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h0000_0000_0000_00FF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD_0   = 3'd0,
    CFG_KEY_WORD_1   = 3'd1,
    CFG_KEY_WORD_2   = 3'd2,
    CFG_KEY_WORD_3   = 3'd3,
    CFG_SIDE_BIT     = 3'd4,
    CFG_EDGE_WIDTH   = 3'd5,
    CFG_BUCKET_WIDTH = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [63:0] key2;
    logic [63:0] key3;
    logic        side;
    logic [5:0]  edge_w;
    logic [3:0]  bucket_w;
  } seg_cfg_t;

  // Payload that travels down the pipeline with each item.
  typedef struct packed {
    sip_state_t  v;
    logic [63:0] nonce;
    logic [5:0]  edge_w;
    logic [34:0] byte_off;
  } seg_pipe_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    logic [63:0] v0, v1, v2, v3;
    sip_state_t  o;
    v0 = s.v0; v1 = s.v1; v2 = s.v2; v3 = s.v3;
    v0 = v0 + v1; v2 = v2 + v3;
    v1 = rotl64(v1, 13); v3 = rotl64(v3, 16);
    v1 = v1 ^ v0; v3 = v3 ^ v2;
    v0 = rotl64(v0, 32);
    v0 = v0 + v3; v2 = v2 + v1;
    v1 = rotl64(v1, 17); v3 = rotl64(v3, 21);
    v1 = v1 ^ v2; v3 = v3 ^ v0;
    v2 = rotl64(v2, 32);
    o.v0 = v0; o.v1 = v1; o.v2 = v2; o.v3 = v3;
    return o;
  endfunction

endpackage

/* hdl/siphash_edge_seed_generator_top.sv */
// Top level of the SipHash edge seed generator: configuration registers,
// map stage, six round stages and the fold/output register. Depends on seg_pkg,
// seg_map and seg_round.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in_     | slave     | in_tvalid/in_tready  | in_tdata: column_number, element_index
//   out_    | master    | out_tvalid/out_tready| out_tdata: node_element, byte_offset
//   cfg_    | write     | cfg_wr_en            | cfg_index, cfg_wdata
//
// One item enters per cycle while the output is not stalled; from acceptance to result
// an item passes one map stage, one stage per SipHash round (six), and the fold stage.
// The whole pipeline advances together; when the output register holds an item
// that is not taken, every stage holds and in_tready is low.
// Reset is synchronous and active low; it clears all valid bits and restores the
// register defaults (keys 0, side 0, edge width 31, bucket width 6).
`timescale 1ns / 1ps
module siphash_edge_seed_generator_top import seg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // [7:0] column_number, [39:8] element_index
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [79:0]           out_tdata,  // [39:0] node_element, [74:40] byte_offset
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  seg_cfg_t    cfg_r;
  logic        en;
  logic        vld_s [0:SIP_ROUNDS];
  seg_pipe_t   pipe_s [0:SIP_ROUNDS];
  seg_pipe_t   rnd_in [0:SIP_ROUNDS-1];

  logic        out_vld_r;
  logic [79:0] out_data_r;
  logic [79:0] out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key0     <= '0;
      cfg_r.key1     <= '0;
      cfg_r.key2     <= '0;
      cfg_r.key3     <= '0;
      cfg_r.side     <= 1'b0;
      cfg_r.edge_w   <= 6'd31;
      cfg_r.bucket_w <= 4'd6;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_WORD_0:   cfg_r.key0     <= cfg_wdata;
        CFG_KEY_WORD_1:   cfg_r.key1     <= cfg_wdata;
        CFG_KEY_WORD_2:   cfg_r.key2     <= cfg_wdata;
        CFG_KEY_WORD_3:   cfg_r.key3     <= cfg_wdata;
        CFG_SIDE_BIT:     cfg_r.side     <= cfg_wdata[0];
        CFG_EDGE_WIDTH:   cfg_r.edge_w   <= cfg_wdata[5:0];
        CFG_BUCKET_WIDTH: cfg_r.bucket_w <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  seg_map u_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .vld_in        (in_tvalid),
    .column_number (in_tdata[7:0]),
    .element_index (in_tdata[39:8]),
    .cfg           (cfg_r),
    .vld_out       (vld_s[0]),
    .pipe_out      (pipe_s[0])
  );

  for (genvar k = 0; k < SIP_ROUNDS; k++) begin : g_round
    if (k == FINAL_ROUND) begin : g_fin
      always_comb begin
        rnd_in[k]      = pipe_s[k];
        rnd_in[k].v.v0 = pipe_s[k].v.v0 ^ pipe_s[k].nonce;
        rnd_in[k].v.v2 = pipe_s[k].v.v2 ^ SIP_FINAL_XOR;
      end
    end else begin : g_pass
      assign rnd_in[k] = pipe_s[k];
    end

    seg_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .vld_in   (vld_s[k]),
      .pipe_in  (rnd_in[k]),
      .vld_out  (vld_s[k+1]),
      .pipe_out (pipe_s[k+1])
    );
  end

  // Fold the state to 32 bits, keep edge_width bits and set the marker bit above them.
  always_comb begin
    logic [63:0] fold;
    logic [31:0] hash;
    logic [32:0] ew_one;
    fold   = pipe_s[SIP_ROUNDS].v.v0 ^ pipe_s[SIP_ROUNDS].v.v1
           ^ pipe_s[SIP_ROUNDS].v.v2 ^ pipe_s[SIP_ROUNDS].v.v3;
    ew_one = 33'd1 << pipe_s[SIP_ROUNDS].edge_w;
    hash   = fold[31:0] & 32'(ew_one - 33'd1);
    out_data_nxt = {5'd0, pipe_s[SIP_ROUNDS].byte_off,
                    {8'd0, hash} | (40'd1 << pipe_s[SIP_ROUNDS].edge_w)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_s[SIP_ROUNDS];
    end
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/seg_map.sv */
// First pipeline stage: clamps the widths, maps column and index to an edge number,
// builds the nonce and the initial SipHash state. Depends on seg_pkg.
`timescale 1ns / 1ps
module seg_map import seg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_in,
  input  logic [7:0]  column_number,
  input  logic [31:0] element_index,
  input  seg_cfg_t    cfg,
  output logic        vld_out,
  output seg_pipe_t   pipe_out
);

  logic        vld_r;
  seg_pipe_t   pipe_r;
  seg_pipe_t   pipe_nxt;

  logic [5:0]  ew;
  logic [3:0]  bw_sat;
  logic [4:0]  bw;
  logic [5:0]  s;
  logic [5:0]  eb;
  logic [32:0] buf_one;
  logic [32:0] low_one;
  logic [31:0] idx_m;
  logic [31:0] edge_num;

  always_comb begin
    if (cfg.edge_w < 6'(MIN_EDGE_WIDTH)) begin
      ew = 6'(MIN_EDGE_WIDTH);
    end else if (cfg.edge_w > 6'(MAX_EDGE_WIDTH)) begin
      ew = 6'(MAX_EDGE_WIDTH);
    end else begin
      ew = cfg.edge_w;
    end
    bw_sat = (cfg.bucket_w > 4'(MAX_BUCKET_WIDTH)) ? 4'(MAX_BUCKET_WIDTH) : cfg.bucket_w;
    // The bucket size must stay at least one element.
    if ({1'b0, bw_sat, 1'b0} > ew) begin
      bw = ew[5:1];
    end else begin
      bw = {1'b0, bw_sat};
    end
    s  = ew - {bw, 1'b0};
    eb = ew - {1'b0, bw};

    buf_one = 33'd1 << eb;
    low_one = 33'd1 << s;
    idx_m   = element_index & 32'(buf_one - 33'd1);

    edge_num = (32'(column_number) << s) + ((idx_m >> s) << eb)
             + (idx_m & 32'(low_one - 33'd1));

    pipe_nxt.nonce    = {31'd0, edge_num, cfg.side};
    pipe_nxt.v.v0     = cfg.key0;
    pipe_nxt.v.v1     = cfg.key1;
    pipe_nxt.v.v2     = cfg.key2;
    pipe_nxt.v.v3     = cfg.key3 ^ pipe_nxt.nonce;
    pipe_nxt.edge_w   = ew;
    pipe_nxt.byte_off = {3'd0, idx_m} * 35'(ELEMENT_BYTES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign pipe_out = pipe_r;

endmodule

/* hdl/seg_round.sv */
// One registered SipHash round stage of the hash pipeline.
// Depends on seg_pkg for the state types and the round function.
`timescale 1ns / 1ps
module seg_round import seg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_in,
  input  seg_pipe_t pipe_in,
  output logic      vld_out,
  output seg_pipe_t pipe_out
);

  logic      vld_r;
  seg_pipe_t pipe_r;
  seg_pipe_t pipe_nxt;

  always_comb begin
    pipe_nxt   = pipe_in;
    pipe_nxt.v = sip_round(pipe_in.v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign pipe_out = pipe_r;

endmodule

/* hdl/seg_checker.sv */
// Port-level checks for the edge seed generator top level, bound to it below.
// Depends only on the stream ports of siphash_edge_seed_generator_top.
`timescale 1ns / 1ps
module seg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // An offered input item stays until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input item changed while waiting");

  // A result that is not taken stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // The pipeline takes items exactly when its output register can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Marker sits at bit 32 at most, and the padding bits stay zero.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:33] == 7'd0) && (out_tdata[79:75] == 5'd0)
                   && (out_tdata[32:0] != 33'd0))
    else $error("node element out of range");

endmodule

bind siphash_edge_seed_generator_top seg_checker u_seg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
